[sv/great_circle_initial_bearing_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the initial bearing core
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_INITIAL_BEARING_CORE_DEFINES_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GCIB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcib assertion failed");
// next-cycle implication
`define GCIB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcib assertion failed");
`else
`define GCIB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GCIB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[sv/gcib_pkg.sv]
// ----------------------------------------------------------------------------
// gcib_pkg
// Shared widths, constants, CORDIC angle table and helpers.
// ----------------------------------------------------------------------------
package gcib_pkg;

   localparam int LON_W     = 31;
   localparam int LAT_W     = 30;
   localparam int BEARING_W = 31;

   localparam int FRAC_BITS_DEF     = 22;
   localparam int CORDIC_STAGES_DEF = 24;
   localparam int MAX_STAGES        = 32;

   localparam int TURN_W   = 32;   // 2^32 = one full turn
   localparam int Q_W      = 32;   // Q30 sin/cos/product values
   localparam int CORDIC_W = 36;   // CORDIC datapath x/y
   localparam int Z_W      = 34;   // CORDIC angle accumulator

   localparam int D2T_LAT     = 7; // register stages of the degree converter
   localparam int NORM_STEPS  = 5; // shifts 16, 8, 4, 2, 1
   localparam int LANES       = 3; // lat1, lat2, dlon

   localparam logic signed [CORDIC_W-1:0] GAIN_INV = 36'sd652032874;
   localparam logic signed [Z_W-1:0] Z_QUARTER = 34'sd1073741824;
   localparam logic signed [Z_W-1:0] Z_HALF    = 34'sd2147483648;

   // divide by 45 through reciprocals, floor exact for the given operand widths
   localparam logic [32:0] DIV_OFFSET = 33'd6039797760;   // 45 * 2^27
   localparam logic [17:0] RECIP_A    = 18'd186414;       // 17-bit operand, >> 23
   localparam logic [22:0] RECIP_B    = 23'd5965233;      // 22-bit operand, >> 28
   localparam logic [23:0] RECIP_C    = 24'd11930465;     // 23-bit operand, >> 29
   localparam logic [5:0]  DIV_45     = 6'd45;
   localparam logic [4:0]  ROUND_22   = 5'd22;            // floor(180 / 8)

   // atan(2^-i) in turns
   localparam logic [31:0] STAGE_ANGLE [MAX_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic             kill;   // force a zero bearing
      logic [LANES-1:0] flip;   // sin/cos lane turned by a half turn
   } side_type;

   // Q30 product, floored
   function automatic logic signed [Q_W-1:0] mul_q30(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
      logic signed [2*Q_W-1:0] p;
      p = a * b;
      return $signed(p[Q_W+29:30]);
   endfunction

endpackage

[sv/gcib_if.sv]
// ----------------------------------------------------------------------------
// gcib_if
// Valid/ready channels for point pairs and bearings.
// ----------------------------------------------------------------------------
interface gcib_req_if;
   import gcib_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [LON_W-1:0] start_lon;
   logic signed [LAT_W-1:0] start_lat;
   logic signed [LON_W-1:0] end_lon;
   logic signed [LAT_W-1:0] end_lat;

   modport source (output valid, start_lon, start_lat, end_lon, end_lat, input ready);
   modport sink   (input valid, start_lon, start_lat, end_lon, end_lat, output ready);
endinterface

interface gcib_rsp_if;
   import gcib_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BEARING_W-1:0] bearing_deg;

   modport source (output valid, bearing_deg, input ready);
   modport sink   (input valid, bearing_deg, output ready);
endinterface

[sv/gcib_deg2turn.sv]
// ----------------------------------------------------------------------------
// gcib_deg2turn
// Degrees to turns: floor((v*2^(29-F) + 22) / 45) mod 2^32, in seven stages.
// ----------------------------------------------------------------------------
module gcib_deg2turn #(
   parameter int ANGLE_FRAC_BITS = gcib_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic [gcib_pkg::D2T_LAT-1:0]         en,
   input  logic signed [gcib_pkg::TURN_W-1:0]   angle,
   output logic [gcib_pkg::TURN_W-1:0]          turns
);
   import gcib_pkg::*;

   localparam int K = TURN_W - 3 - ANGLE_FRAC_BITS;

   logic [32:0] vp_ff, vp_in;
   logic [16:0] a2_ff;
   logic [15:0] b2_ff;
   logic [34:0] pa_ff;
   logic [11:0] qa3_ff, qa4_ff, qa5_ff, qa6_ff, qa;
   logic [21:0] n2_ff, n2b_ff, n2_in;
   logic [44:0] pb_ff;
   logic [16:0] qb, qb5_ff, qb6_ff;
   logic [22:0] n3_ff, n3_in;
   logic [46:0] p3_ff;
   logic [16:0] ra_w;
   logic [21:0] rb_w;
   logic [28:0] qfull;
   logic [63:0] tsum;
   logic [TURN_W-1:0] turns_ff, turns_in;

   always_comb begin
      vp_in = 33'({{2{angle[TURN_W-1]}}, angle} + 34'(DIV_OFFSET));
      qa    = pa_ff[34:23];
      ra_w  = a2_ff - 17'(qa * DIV_45);
      n2_in = {ra_w[5:0], b2_ff};
      qb    = pb_ff[44:28];
      rb_w  = n2b_ff - 22'(qb * DIV_45);
      n3_in = (23'(rb_w[5:0]) << K) + 23'(ROUND_22);
      qfull = {5'b0, qa6_ff, 12'b0} * 29'd16 + 29'(qb6_ff);
      tsum  = (64'(qfull) << K) + 64'(p3_ff[46:29]);
      turns_in = tsum[TURN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) vp_ff <= vp_in;
      if (en[1]) begin
         a2_ff <= vp_ff[32:16];
         b2_ff <= vp_ff[15:0];
         pa_ff <= 35'(vp_ff[32:16]) * 35'(RECIP_A);
      end
      if (en[2]) begin
         qa3_ff <= qa;
         n2_ff  <= n2_in;
      end
      if (en[3]) begin
         qa4_ff <= qa3_ff;
         n2b_ff <= n2_ff;
         pb_ff  <= 45'(n2_ff) * 45'(RECIP_B);
      end
      if (en[4]) begin
         qa5_ff <= qa4_ff;
         qb5_ff <= qb;
         n3_ff  <= n3_in;
      end
      if (en[5]) begin
         qa6_ff <= qa5_ff;
         qb6_ff <= qb5_ff;
         p3_ff  <= 47'(n3_ff) * 47'(RECIP_C);
      end
      if (en[6]) turns_ff <= turns_in;
   end

   assign turns = turns_ff;

endmodule

[sv/gcib_cordic_cell.sv]
// ----------------------------------------------------------------------------
// gcib_cordic_cell
// One CORDIC micro-rotation with its output register (rotation or vectoring).
// ----------------------------------------------------------------------------
module gcib_cordic_cell #(
   parameter int   STAGE     = 0,
   parameter bit   VECTORING = 1'b0
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [gcib_pkg::CORDIC_W-1:0]  x_in,
   input  logic signed [gcib_pkg::CORDIC_W-1:0]  y_in,
   input  logic signed [gcib_pkg::Z_W-1:0]       z_in,
   output logic signed [gcib_pkg::CORDIC_W-1:0]  x_out,
   output logic signed [gcib_pkg::CORDIC_W-1:0]  y_out,
   output logic signed [gcib_pkg::Z_W-1:0]       z_out
);
   import gcib_pkg::*;

   localparam logic signed [Z_W-1:0] ANGLE = $signed(Z_W'(STAGE_ANGLE[STAGE]));

   logic signed [CORDIC_W-1:0] xs, ys, x_ff, y_ff, x_in2, y_in2;
   logic signed [Z_W-1:0]      z_ff, z_in2;
   logic                       cw;

   always_comb begin
      xs = x_in >>> STAGE;
      ys = y_in >>> STAGE;
      // clockwise: y still positive when vectoring, angle left negative when rotating
      cw = VECTORING ? !y_in[CORDIC_W-1] : z_in[Z_W-1];
      if (cw) begin
         x_in2 = x_in + ys;
         y_in2 = y_in - xs;
         z_in2 = z_in + ANGLE;
      end else begin
         x_in2 = x_in - ys;
         y_in2 = y_in + xs;
         z_in2 = z_in - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in2;
         y_ff <= y_in2;
         z_ff <= z_in2;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

[sv/gcib_norm_step.sv]
// ----------------------------------------------------------------------------
// gcib_norm_step
// One step of the vector pre-scale: shift left until one part reaches 1.0.
// ----------------------------------------------------------------------------
module gcib_norm_step #(
   parameter int SHIFT = 16
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [gcib_pkg::CORDIC_W-1:0]  x_in,
   input  logic signed [gcib_pkg::CORDIC_W-1:0]  y_in,
   input  logic signed [gcib_pkg::Z_W-1:0]       z_in,
   output logic signed [gcib_pkg::CORDIC_W-1:0]  x_out,
   output logic signed [gcib_pkg::CORDIC_W-1:0]  y_out,
   output logic signed [gcib_pkg::Z_W-1:0]       z_out
);
   import gcib_pkg::*;

   // shift only while the larger part stays below 2.0 afterwards
   localparam logic signed [CORDIC_W-1:0] LIMIT = CORDIC_W'(1) <<< (31 - SHIFT);

   logic signed [CORDIC_W-1:0] ay, x_ff, y_ff;
   logic signed [Z_W-1:0]      z_ff;
   logic                       small_vec;

   always_comb begin
      ay        = y_in[CORDIC_W-1] ? -y_in : y_in;
      small_vec = (x_in < LIMIT) && (ay < LIMIT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= small_vec ? (x_in <<< SHIFT) : x_in;
         y_ff <= small_vec ? (y_in <<< SHIFT) : y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

[sv/great_circle_initial_bearing_core.sv]
// ----------------------------------------------------------------------------
// great_circle_initial_bearing_core
// Initial great-circle bearing from a start point to an end point.
// ----------------------------------------------------------------------------
// Takes one point pair per item (longitudes and latitudes in signed degrees
// with ANGLE_FRAC_BITS fraction bits) and returns the forward azimuth in
// degrees, 0 up to just below 360, same format. The block is a fully
// pipelined row of cells: a seven-stage degree-to-turn converter for lat1,
// lat2 and dlon, a row of CORDIC_STAGES rotation cells per lane for sin/cos,
// three stages of Q30 products, a five-step pre-scale and a row of
// CORDIC_STAGES vectoring cells for atan2, then the degree conversion into the
// output register. It accepts one item every clock while the output is taken.
// Every stage holds its own valid bit and moves whenever the stage after it is
// empty or moving, so a stalled result only holds the input side off once all
// stages are full. Coincident points and a zero vector give a bearing of 0; a
// result that rounds to 360 saturates just below it.
// ----------------------------------------------------------------------------
`include "great_circle_initial_bearing_core_defines.svh"

module great_circle_initial_bearing_core #(
   parameter int ANGLE_FRAC_BITS = gcib_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = gcib_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gcib_req_if.sink    req_chan,
   gcib_rsp_if.source  rsp_chan
);
   import gcib_pkg::*;

   // stage map
   localparam int C            = CORDIC_STAGES;
   localparam int ST_SC_PREP   = D2T_LAT + 1;
   localparam int ST_SC        = ST_SC_PREP + C + 1;
   localparam int ST_M1        = ST_SC + 1;
   localparam int ST_M2        = ST_M1 + 1;
   localparam int ST_DIFF      = ST_M2 + 1;
   localparam int ST_VEC_PREP  = ST_DIFF + 1;
   localparam int ST_OUT       = ST_VEC_PREP + NORM_STEPS + C + 1;
   localparam int L            = ST_OUT + 1;
   localparam int VCH          = NORM_STEPS + C + 1;

   localparam logic [40:0] OUT_FULL  = 41'd360 << ANGLE_FRAC_BITS;
   localparam logic [40:0] OUT_ROUND = 41'd1 << (31 - ANGLE_FRAC_BITS);

   // ---------------- stage control ----------------
   logic [L-1:0] valid_ff, valid_in, stage_en;
   side_type     side_ff [L];
   side_type     side_in [L];

   // a stage moves when it or any stage after it has a hole, or the sink takes
   for (genvar s = 0; s < L; s++) begin : g_en
      assign stage_en[s] = rsp_chan.ready || !(&valid_ff[L-1:s]);
   end

   assign valid_in = (stage_en & {valid_ff[L-2:0], req_chan.valid}) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar s = 0; s < L; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (stage_en[s]) side_ff[s] <= side_in[s];
      end
   end

   assign req_chan.ready = stage_en[0];

   // ---------------- input register ----------------
   logic signed [LON_W-1:0] lon1_ff, lon2_ff;
   logic signed [LAT_W-1:0] lat1_ff, lat2_ff;
   logic                    coinc;

   assign coinc = (req_chan.start_lon == req_chan.end_lon) &&
                  (req_chan.start_lat == req_chan.end_lat);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         lon1_ff <= req_chan.start_lon;
         lat1_ff <= req_chan.start_lat;
         lon2_ff <= req_chan.end_lon;
         lat2_ff <= req_chan.end_lat;
      end
   end

   // ---------------- degrees to turns ----------------
   logic signed [TURN_W-1:0] conv_angle [LANES];
   logic [TURN_W-1:0]        turn_w     [LANES];

   assign conv_angle[0] = TURN_W'(lat1_ff);
   assign conv_angle[1] = TURN_W'(lat2_ff);
   assign conv_angle[2] = TURN_W'(lon2_ff) - TURN_W'(lon1_ff);   // exact dlon

   for (genvar l = 0; l < LANES; l++) begin : g_conv
      gcib_deg2turn #(
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
      ) u_conv (
         .clock (clock),
         .en    (stage_en[D2T_LAT:1]),
         .angle (conv_angle[l]),
         .turns (turn_w[l])
      );
   end

   // ---------------- sin/cos rows ----------------
   logic signed [Z_W-1:0] prep_z_ff [LANES];
   logic signed [Z_W-1:0] prep_z_in [LANES];
   logic [LANES-1:0]      sc_flip;
   wire signed [CORDIC_W-1:0] rx [LANES][C+1];
   wire signed [CORDIC_W-1:0] ry [LANES][C+1];
   wire signed [Z_W-1:0]      rz [LANES][C+1];

   // fold into [-90, 90] degrees, negate the results later
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prep_z_in[l] = Z_W'($signed(turn_w[l]));
         sc_flip[l]   = 1'b0;
         if (prep_z_in[l] > Z_QUARTER) begin
            prep_z_in[l] = prep_z_in[l] - Z_HALF;
            sc_flip[l]   = 1'b1;
         end else if (prep_z_in[l] < -Z_QUARTER) begin
            prep_z_in[l] = prep_z_in[l] + Z_HALF;
            sc_flip[l]   = 1'b1;
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_rot
      always_ff @(posedge clock) begin
         if (stage_en[ST_SC_PREP]) prep_z_ff[l] <= prep_z_in[l];
      end

      assign rx[l][0] = GAIN_INV;
      assign ry[l][0] = '0;
      assign rz[l][0] = prep_z_ff[l];

      for (genvar j = 0; j < C; j++) begin : g_cell
         gcib_cordic_cell #(
            .STAGE     (j),
            .VECTORING (1'b0)
         ) u_cell (
            .clock (clock),
            .en    (stage_en[ST_SC_PREP + 1 + j]),
            .x_in  (rx[l][j]),
            .y_in  (ry[l][j]),
            .z_in  (rz[l][j]),
            .x_out (rx[l][j+1]),
            .y_out (ry[l][j+1]),
            .z_out (rz[l][j+1])
         );
      end
   end

   // ---------------- sin/cos out, products ----------------
   logic signed [Q_W-1:0]      sin_ff [LANES];
   logic signed [Q_W-1:0]      cos_ff [LANES];
   logic signed [CORDIC_W-1:0] sin_w  [LANES];
   logic signed [CORDIC_W-1:0] cos_w  [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         sin_w[l] = side_ff[ST_SC-1].flip[l] ? -ry[l][C] : ry[l][C];
         cos_w[l] = side_ff[ST_SC-1].flip[l] ? -rx[l][C] : rx[l][C];
      end
   end

   logic signed [Q_W-1:0] yp1_ff, ap1_ff, bp1_ff, cd1_ff;
   logic signed [Q_W-1:0] yp2_ff, ap2_ff, pbc_ff;
   logic signed [Q_W:0]   xd_ff;
   logic signed [Q_W-1:0] yd_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_SC]) begin
         for (int l = 0; l < LANES; l++) begin
            sin_ff[l] <= $signed(sin_w[l][Q_W-1:0]);
            cos_ff[l] <= $signed(cos_w[l][Q_W-1:0]);
         end
      end
      // y = sin(dlon)cos(lat2); x terms cos(lat1)sin(lat2), sin(lat1)cos(lat2)
      if (stage_en[ST_M1]) begin
         yp1_ff <= mul_q30(sin_ff[2], cos_ff[1]);
         ap1_ff <= mul_q30(cos_ff[0], sin_ff[1]);
         bp1_ff <= mul_q30(sin_ff[0], cos_ff[1]);
         cd1_ff <= cos_ff[2];
      end
      if (stage_en[ST_M2]) begin
         yp2_ff <= yp1_ff;
         ap2_ff <= ap1_ff;
         pbc_ff <= mul_q30(bp1_ff, cd1_ff);
      end
      if (stage_en[ST_DIFF]) begin
         xd_ff <= (Q_W+1)'(ap2_ff) - (Q_W+1)'(pbc_ff);
         yd_ff <= yp2_ff;
      end
   end

   // ---------------- atan2: prep, pre-scale, vectoring row ----------------
   wire signed [CORDIC_W-1:0] vx [VCH];
   wire signed [CORDIC_W-1:0] vy [VCH];
   wire signed [Z_W-1:0]      vz [VCH];
   logic signed [CORDIC_W-1:0] vp_x_ff, vp_y_ff, xd_ext, yd_ext;
   logic signed [Z_W-1:0]      vp_z_ff;
   logic                       vec_zero, vec_neg;

   always_comb begin
      xd_ext   = CORDIC_W'(xd_ff);
      yd_ext   = CORDIC_W'(yd_ff);
      vec_zero = (xd_ff == '0) && (yd_ff == '0);
      vec_neg  = xd_ff[Q_W];
   end

   // left half-plane: negate the vector and start from a half turn
   always_ff @(posedge clock) begin
      if (stage_en[ST_VEC_PREP]) begin
         vp_x_ff <= vec_neg ? -xd_ext : xd_ext;
         vp_y_ff <= vec_neg ? -yd_ext : yd_ext;
         vp_z_ff <= vec_neg ? Z_HALF : '0;
      end
   end

   assign vx[0] = vp_x_ff;
   assign vy[0] = vp_y_ff;
   assign vz[0] = vp_z_ff;

   for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
      gcib_norm_step #(
         .SHIFT (16 >> k)
      ) u_norm (
         .clock (clock),
         .en    (stage_en[ST_VEC_PREP + 1 + k]),
         .x_in  (vx[k]),
         .y_in  (vy[k]),
         .z_in  (vz[k]),
         .x_out (vx[k+1]),
         .y_out (vy[k+1]),
         .z_out (vz[k+1])
      );
   end

   for (genvar j = 0; j < C; j++) begin : g_vec
      gcib_cordic_cell #(
         .STAGE     (j),
         .VECTORING (1'b1)
      ) u_cell (
         .clock (clock),
         .en    (stage_en[ST_VEC_PREP + NORM_STEPS + 1 + j]),
         .x_in  (vx[NORM_STEPS + j]),
         .y_in  (vy[NORM_STEPS + j]),
         .z_in  (vz[NORM_STEPS + j]),
         .x_out (vx[NORM_STEPS + j + 1]),
         .y_out (vy[NORM_STEPS + j + 1]),
         .z_out (vz[NORM_STEPS + j + 1])
      );
   end

   // ---------------- sideband ----------------
   always_comb begin
      side_in[0] = '{kill: coinc, flip: '0};
      for (int s = 1; s < L; s++) begin
         side_in[s] = side_ff[s-1];
      end
      side_in[ST_SC_PREP].flip  = sc_flip;
      side_in[ST_VEC_PREP].kill = side_ff[ST_VEC_PREP-1].kill | vec_zero;
   end

   // ---------------- turns to degrees, output register ----------------
   logic [TURN_W-1:0]    out_t;
   logic [40:0]          out_prod, out_r;
   logic [BEARING_W-1:0] bearing_ff, bearing_in;

   always_comb begin
      out_t    = vz[VCH-1][TURN_W-1:0];   // angle wraps modulo one turn
      out_prod = 41'(out_t) * 41'd360;
      out_r    = (out_prod + OUT_ROUND) >> (32 - ANGLE_FRAC_BITS);
      if (out_r >= OUT_FULL) out_r = OUT_FULL - 41'd1;
      bearing_in = side_ff[ST_OUT-1].kill ? '0 : out_r[BEARING_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) bearing_ff <= bearing_in;
   end

   assign rsp_chan.valid       = valid_ff[ST_OUT];
   assign rsp_chan.bearing_deg = bearing_ff;

   // ---------------- assertions ----------------
   `GCIB_ASSERT_IMP(a_stall_only_full, clock, reset, !req_chan.ready, &valid_ff)
   `GCIB_ASSERT_NXT(a_no_drop, clock, reset, valid_ff[ST_OUT-1] && stage_en[ST_OUT], valid_ff[ST_OUT])
   `GCIB_ASSERT_IMP(a_out_range, clock, reset, rsp_chan.valid, 41'(rsp_chan.bearing_deg) < OUT_FULL)

endmodule
